### src/c8frx_pkg.sv
// Package for the CRC-8 framed packet receiver.
// Holds the frame constants, the result record and the byte-wide CRC-8 step.
// No dependencies.
package c8frx_pkg;

  // Reflected CRC-8 polynomial (right-shifting register form)
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  // First byte of every good frame
  localparam logic [7:0] HEADER_MARK = 8'hAA;
  // Bytes 1..7 of a frame carry the payload
  localparam int unsigned PAYLOAD_DEPTH = 7;

  // Decoded result of one completed frame
  typedef struct packed {
    logic       frame_ok;
    logic       water_full_open;
    logic       pump_full_closed;
    logic       tilt_open;
    logic       pipe_open;
    logic       halt_reply;
    logic [9:0] room_temp_raw;
    logic [8:0] coil_temp_raw;
    logic [9:0] humidity_raw;
    logic [7:0] humidity_value;
    logic [8:0] comp_temp_raw;
  } result_t;

  // One byte through the CRC-8: eight shift steps, fully unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/crc8_frame_receiver_decoder.sv
// Top level of the CRC-8 framed packet receiver and decoder.
// Depends on c8frx_pkg (constants, result record, CRC-8 step).
//
// Usage:
//   Byte channel (rx_byte, frame_start, byte_valid/byte_stall): one received
//   byte per transfer. frame_start marks byte 0 of a frame and restarts
//   capture, dropping any partial frame. Bytes outside an open frame are
//   dropped silently.
//   Result channel (frame_ok and decoded fields, result_valid/result_stall):
//   one transfer per completed frame, taken on byte FRAME_LEN-1 (the CRC
//   byte). When frame_ok is low every decoded field reads zero.
//   Throughput: one byte per cycle while byte_stall is low; the CRC-8
//   step, header check and payload capture all complete in the cycle the
//   byte is taken. A result is registered when its CRC byte is taken.
//   Stall: the result register is backed by one skid entry, so bytes keep
//   flowing while a result waits. byte_stall rises only once the skid entry
//   is holding a second result; it is a register output.
//   Reset (rst, synchronous): closes any open frame, clears the CRC and
//   header flag, and empties both result registers.
module crc8_frame_receiver_decoder #(
  parameter int unsigned FRAME_LEN = 9
) (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic       byte_valid,
  output logic       byte_stall,
  // result channel
  output logic       frame_ok,
  output logic       water_full_open,
  output logic       pump_full_closed,
  output logic       tilt_open,
  output logic       pipe_open,
  output logic       halt_reply,
  output logic [9:0] room_temp_raw,
  output logic [8:0] coil_temp_raw,
  output logic [9:0] humidity_raw,
  output logic [7:0] humidity_value,
  output logic [8:0] comp_temp_raw,
  output logic       result_valid,
  input  logic       result_stall
);
  import c8frx_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  // frame state
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       running_crc;
  logic             header_good;
  logic [7:0]       payload_bytes [PAYLOAD_DEPTH];

  // result register and skid entry
  result_t out_res, skid_res;
  logic    out_v, skid_v;

  logic             take;
  logic             frame_open;
  logic [IDX_W-1:0] pos;
  logic [7:0]       crc_in;
  logic             last_byte;
  logic             produce;
  logic             ok;
  result_t          res_next;

  assign take       = byte_valid && !byte_stall;
  assign frame_open = frame_start || (byte_index != '0);
  assign pos        = frame_start ? '0 : byte_index;
  assign crc_in     = frame_start ? 8'h00 : running_crc;
  assign last_byte  = (pos == LAST_IDX);
  assign produce    = take && frame_open && last_byte;
  assign ok         = header_good && (rx_byte == running_crc);

  // decode the stored payload; all zero on a bad frame
  always_comb begin
    res_next = '0;
    if (ok) begin
      res_next.frame_ok         = 1'b1;
      res_next.water_full_open  = payload_bytes[0][0];
      res_next.pump_full_closed = payload_bytes[0][1];
      res_next.tilt_open        = payload_bytes[0][5];
      res_next.pipe_open        = payload_bytes[0][7];
      res_next.halt_reply       = payload_bytes[0][6];
      res_next.room_temp_raw    = {payload_bytes[1][1:0], payload_bytes[2]};
      res_next.coil_temp_raw    = {payload_bytes[1][3:2], payload_bytes[3][7:1]};
      res_next.humidity_raw     = {payload_bytes[1][5:4], payload_bytes[4]};
      res_next.humidity_value   = payload_bytes[5];
      res_next.comp_temp_raw    = {payload_bytes[1][7:6], payload_bytes[6][7:1]};
    end
  end

  // frame tracking: CRC, header flag, byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_crc <= 8'h00;
      header_good <= 1'b0;
    end else if (take && frame_open) begin
      if (last_byte) begin
        byte_index  <= '0;
        running_crc <= 8'h00;
        header_good <= 1'b0;
      end else begin
        byte_index  <= pos + 1'b1;
        running_crc <= crc8_byte(crc_in, rx_byte);
        if (pos == '0) begin
          header_good <= (rx_byte == HEADER_MARK);
        end
      end
    end
  end

  // payload capture, bytes 1..7
  for (genvar i = 0; i < PAYLOAD_DEPTH; i++) begin : g_payload
    always_ff @(posedge clk) begin
      if (take && frame_open && !last_byte && (pos == IDX_W'(i + 1))) begin
        payload_bytes[i] <= rx_byte;
      end
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && result_stall) begin
      if (produce) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && result_stall) begin
      if (produce) begin
        skid_res <= res_next;
      end
    end else if (skid_v) begin
      out_res <= skid_res;
    end else if (produce) begin
      out_res <= res_next;
    end
  end

  assign byte_stall       = skid_v;
  assign result_valid     = out_v;
  assign frame_ok         = out_res.frame_ok;
  assign water_full_open  = out_res.water_full_open;
  assign pump_full_closed = out_res.pump_full_closed;
  assign tilt_open        = out_res.tilt_open;
  assign pipe_open        = out_res.pipe_open;
  assign halt_reply       = out_res.halt_reply;
  assign room_temp_raw    = out_res.room_temp_raw;
  assign coil_temp_raw    = out_res.coil_temp_raw;
  assign humidity_raw     = out_res.humidity_raw;
  assign humidity_value   = out_res.humidity_value;
  assign comp_temp_raw    = out_res.comp_temp_raw;

endmodule

### src/c8frx_checker.sv
// Port-level checks for the CRC-8 framed packet receiver.
// Bound to crc8_frame_receiver_decoder; sees its ports only.
module c8frx_checker (
  input logic       clk,
  input logic       rst,
  input logic       frame_start,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic       frame_ok,
  input logic       water_full_open,
  input logic       pump_full_closed,
  input logic       tilt_open,
  input logic       pipe_open,
  input logic       halt_reply,
  input logic [9:0] room_temp_raw,
  input logic [8:0] coil_temp_raw,
  input logic [9:0] humidity_raw,
  input logic [7:0] humidity_value,
  input logic [8:0] comp_temp_raw,
  input logic       result_valid,
  input logic       result_stall
);

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(frame_ok) && $stable(room_temp_raw)
      && $stable(coil_temp_raw) && $stable(humidity_raw) && $stable(humidity_value)
      && $stable(comp_temp_raw) && $stable(water_full_open) && $stable(halt_reply))
    else $error("result changed while stalled");

  // a bad frame reports all fields zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_ok |-> !water_full_open && !pump_full_closed && !tilt_open
      && !pipe_open && !halt_reply && room_temp_raw == 10'd0 && coil_temp_raw == 9'd0
      && humidity_raw == 10'd0 && humidity_value == 8'd0 && comp_temp_raw == 9'd0)
    else $error("bad frame with nonzero fields");

  // a new result follows a CRC byte transfer that was not a frame start
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_valid && !byte_stall && !frame_start))
    else $error("result without a closing byte");

endmodule

bind crc8_frame_receiver_decoder c8frx_checker u_c8frx_checker (.*);

### tb/sv/tb_crc8_frame_receiver_decoder.sv
// Testbench for crc8_frame_receiver_decoder: random and directed byte streams, checked
// frame by frame against a CRC-8 and payload decoder written into the scoreboard.
// Depends on c8frx_pkg (result record, header mark, polynomial) and the RTL top level.
module tb_crc8_frame_receiver_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import c8frx_pkg::*;

  localparam int unsigned FLEN     = 9;
  localparam int          LIMIT    = 100000;
  localparam int          HOLD_LEN = 150;

  // Tracks the open frame and holds the decoded results still owed by the block
  class rx_frame_tracker;
    int unsigned frame_len;
    logic [4:0]  pos;
    logic [7:0]  crc_acc;
    logic        hdr_ok;
    logic [7:0]  payload [PAYLOAD_DEPTH];
    result_t     expected_frames [$];
    int          errors;
    int          frames_seen;

    function new(int unsigned flen);
      frame_len   = flen;
      pos         = '0;
      crc_acc     = '0;
      hdr_ok      = 1'b0;
      errors      = 0;
      frames_seen = 0;
    endfunction

    // Reflected CRC-8, one data bit at a time, LSB first
    static function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb  = acc[0] ^ d[i];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ CRC_POLY;
        end
      end
      return acc;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // Accepted byte: advance the frame and queue a result on the CRC byte
    function void note_byte(logic [7:0] b, logic start);
      result_t    r;
      logic       ok;
      logic [7:0] st;
      logic [7:0] hi;
      if (start) begin
        pos     = '0;
        crc_acc = '0;
        hdr_ok  = 1'b0;
      end else if (pos == 0) begin
        return;  // no frame open, byte dropped
      end
      if (pos < frame_len - 1) begin
        crc_acc = crc8_step(crc_acc, b);
        if (pos == 0) begin
          hdr_ok = (b == HEADER_MARK);
        end else if (pos <= PAYLOAD_DEPTH) begin
          payload[pos - 1] = b;
        end
        pos = pos + 1'b1;
        return;
      end
      // CRC byte closes the frame
      ok      = hdr_ok && (b == crc_acc);
      pos     = '0;
      crc_acc = '0;
      hdr_ok  = 1'b0;
      r       = '0;
      if (ok) begin
        st                 = payload[0];
        hi                 = payload[1];
        r.frame_ok         = 1'b1;
        r.water_full_open  = st[0];
        r.pump_full_closed = st[1];
        r.tilt_open        = st[5];
        r.pipe_open        = st[7];
        r.halt_reply       = st[6];
        r.room_temp_raw    = {hi[1:0], payload[2]};
        r.coil_temp_raw    = {hi[3:2], payload[3][7:1]};
        r.humidity_raw     = {hi[5:4], payload[4]};
        r.humidity_value   = payload[5];
        r.comp_temp_raw    = {hi[7:6], payload[6][7:1]};
      end
      expected_frames.push_back(r);
    endfunction

    task report(string what);
      $display("%0t ns frame %0d: %s", $time, frames_seen, what);
      errors++;
    endtask

    task cmp_field(string name, int unsigned got_v, int unsigned want_v);
      if (got_v != want_v) begin
        report($sformatf("%s got %0h want %0h", name, got_v, want_v));
      end
    endtask

    // Accepted result: compare with the oldest owed frame
    task check_result(result_t got);
      result_t want;
      if (expected_frames.size() == 0) begin
        report("result transfer with no frame owed");
        return;
      end
      want = expected_frames.pop_front();
      cmp_field("frame_ok", got.frame_ok, want.frame_ok);
      cmp_field("water_full_open", got.water_full_open, want.water_full_open);
      cmp_field("pump_full_closed", got.pump_full_closed, want.pump_full_closed);
      cmp_field("tilt_open", got.tilt_open, want.tilt_open);
      cmp_field("pipe_open", got.pipe_open, want.pipe_open);
      cmp_field("halt_reply", got.halt_reply, want.halt_reply);
      cmp_field("room_temp_raw", got.room_temp_raw, want.room_temp_raw);
      cmp_field("coil_temp_raw", got.coil_temp_raw, want.coil_temp_raw);
      cmp_field("humidity_raw", got.humidity_raw, want.humidity_raw);
      cmp_field("humidity_value", got.humidity_value, want.humidity_value);
      cmp_field("comp_temp_raw", got.comp_temp_raw, want.comp_temp_raw);
      frames_seen++;
    endtask
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic [7:0] rx_byte      = 8'h00;
  logic       frame_start  = 1'b0;
  logic       byte_valid   = 1'b0;
  logic       result_stall = 1'b0;
  logic       byte_stall;
  logic       frame_ok;
  logic       water_full_open;
  logic       pump_full_closed;
  logic       tilt_open;
  logic       pipe_open;
  logic       halt_reply;
  logic [9:0] room_temp_raw;
  logic [8:0] coil_temp_raw;
  logic [9:0] humidity_raw;
  logic [7:0] humidity_value;
  logic [8:0] comp_temp_raw;
  logic       result_valid;
  result_t    seen_result;

  rx_frame_tracker frames;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  hold_reqs   = 0;
  int  items_sent  = 0;
  int  cyc         = 0;
  bit  offering    = 1'b0;
  bit  frame_open  = 1'b0;

  crc8_frame_receiver_decoder #(.FRAME_LEN(FLEN)) uut (
    .clk              (clk),
    .rst              (rst),
    .rx_byte          (rx_byte),
    .frame_start      (frame_start),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_ok         (frame_ok),
    .water_full_open  (water_full_open),
    .pump_full_closed (pump_full_closed),
    .tilt_open        (tilt_open),
    .pipe_open        (pipe_open),
    .halt_reply       (halt_reply),
    .room_temp_raw    (room_temp_raw),
    .coil_temp_raw    (coil_temp_raw),
    .humidity_raw     (humidity_raw),
    .humidity_value   (humidity_value),
    .comp_temp_raw    (comp_temp_raw),
    .result_valid     (result_valid),
    .result_stall     (result_stall)
  );

  assign seen_result = {frame_ok, water_full_open, pump_full_closed, tilt_open, pipe_open,
                        halt_reply, room_temp_raw, coil_temp_raw, humidity_raw,
                        humidity_value, comp_temp_raw};

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial frames = new(FLEN);

  // Watch both channels and score every transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        frames.note_byte(rx_byte, frame_start);
      end
      if (result_valid && !result_stall) begin
        frames.check_result(seen_result);
      end
    end
  end

  // Result side: random stall, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Verification failed");
    $finish;
  end

  // One byte transfer, then maybe an idle gap with junk on the bus
  task automatic send_byte(input logic [7:0] b, input logic start);
    byte_valid  <= 1'b1;
    rx_byte     <= b;
    frame_start <= start;
    offering    = 1'b1;
    do @(posedge clk); while (byte_stall);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      byte_valid  <= 1'b0;
      rx_byte     <= 8'($urandom);
      frame_start <= 1'($urandom);
      offering    = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // First nbytes bytes of a frame; the CRC byte is xored with crc_flip
  task automatic send_frame(input logic [7:0] hdr, input int nbytes, input logic [7:0] crc_flip,
                            input bit use_fill, input logic [7:0] fill);
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'h00;
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) begin
        b = hdr;
      end else if (i == FLEN - 1) begin
        b = acc ^ crc_flip;
      end else begin
        b = use_fill ? fill : pick_byte();
      end
      if (i < FLEN - 1) begin
        acc = rx_frame_tracker::crc8_step(acc, b);
      end
      send_byte(b, i == 0);
    end
    items_sent += nbytes;
    frame_open = (nbytes < FLEN);
  endtask

  // Stop offering and wait until every owed result has been taken;
  // first let the monitor score the last byte transfer
  task automatic drain();
    if (offering) begin
      byte_valid <= 1'b0;
      offering   = 1'b0;
    end
    @(posedge clk);
    while (frames.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly good frames; bad CRC, bad header, cut frames and stray bytes mixed in
  task automatic run_random(input int n);
    int         stop_at;
    int         pick;
    logic [7:0] hdr;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(HEADER_MARK, FLEN, 8'h00, 1'b0, 8'h00);
      end else if (pick < 78) begin
        send_frame(HEADER_MARK, FLEN, 8'($urandom_range(1, 255)), 1'b0, 8'h00);
      end else if (pick < 85) begin
        hdr = 8'($urandom);
        if (hdr == HEADER_MARK) begin
          hdr = ~hdr;
        end
        send_frame(hdr, FLEN, 8'h00, 1'b0, 8'h00);
      end else if (pick < 92) begin
        send_frame(HEADER_MARK, $urandom_range(1, FLEN - 1), 8'h00, 1'b0, 8'h00);
      end else if (!frame_open) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Main sequence
  initial begin
    tx_idle_pct = 9;
    rx_idle_pct = 72;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray byte, cut frame then restart, all-ones frame, stray byte, all-zero frame
    send_byte(8'hFF, 1'b0);
    send_frame(HEADER_MARK, 2, 8'h00, 1'b1, 8'hFF);
    send_frame(HEADER_MARK, FLEN, 8'h00, 1'b1, 8'hFF);
    send_byte(8'h00, 1'b0);
    send_frame(HEADER_MARK, FLEN, 8'h00, 1'b1, 8'h00);
    drain();

    run_random(260);
    drain();

    tx_idle_pct = 72;
    rx_idle_pct = 9;
    run_random(260);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(120);
    // Long receiver hold-off while frames keep coming, so the skid fills and bytes stall
    hold_reqs <= hold_reqs + 1;
    repeat (6) send_frame(HEADER_MARK, FLEN, 8'h00, 1'b0, 8'h00);
    run_random(100);
    drain();

    repeat (6) @(posedge clk);
    if (frames.errors == 0 && frames.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
